@@ rtl/segment_distance_unit_assert.svh @@
// Assertion macros shared by the segment distance unit RTL.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef SEGMENT_DISTANCE_UNIT_ASSERT_SVH
`define SEGMENT_DISTANCE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment distance unit: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment distance unit: assertion failed");
`else
`define SDU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sdu_pkg.sv @@
// Shared types and constants of the segment distance unit.
// No dependencies; sdu_query, sdu_div, sdu_sqrt and segment_distance_unit import this package.
package sdu_pkg;

  // Latency of one point-to-segment query front end.
  localparam int unsigned QUERY_LAT = 6;

  // The four point-to-segment queries of segment mode.
  localparam int unsigned QRY_B_A0 = 0;  // segment B, point A start
  localparam int unsigned QRY_B_A1 = 1;  // segment B, point A end
  localparam int unsigned QRY_A_B0 = 2;  // segment A, point B start
  localparam int unsigned QRY_A_B1 = 3;  // segment A, point B end
  localparam int unsigned QRY_NUM  = 4;

  typedef enum logic {
    CMD_SEG_SEG = 1'b0,
    CMD_SEG_PT  = 1'b1
  } sdu_cmd_t;

  // Per-query flags: squared distance is zero, sign of the cross product.
  typedef struct packed {
    logic zero;
    logic pos;
    logic neg;
  } sdu_flags_t;

  // Control that travels beside the query pipelines.
  typedef struct packed {
    logic     valid;
    sdu_cmd_t cmd;
    logic     adeg;
    logic     bdeg;
  } sdu_side_t;

  // Control that travels beside the square root pipeline.
  typedef struct packed {
    logic valid;
    logic touching;
    logic degenerate;
  } sdu_tail_t;

endpackage

@@ rtl/sdu_if.sv @@
// Valid/ready channel interfaces of the segment distance unit.
// Depends on nothing; widths follow COORD_WIDTH.
interface sdu_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [COORD_WIDTH-1:0] a_start_x;
  logic signed [COORD_WIDTH-1:0] a_start_y;
  logic signed [COORD_WIDTH-1:0] a_end_x;
  logic signed [COORD_WIDTH-1:0] a_end_y;
  logic signed [COORD_WIDTH-1:0] b_start_x;
  logic signed [COORD_WIDTH-1:0] b_start_y;
  logic signed [COORD_WIDTH-1:0] b_end_x;
  logic signed [COORD_WIDTH-1:0] b_end_y;

  modport source (output valid, cmd, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, cmd, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sdu_out_if #(parameter int COORD_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [COORD_WIDTH:0] distance;
  logic                 touching;
  logic                 degenerate;

  modport source (output valid, distance, touching, degenerate, input ready);
  modport sink (input valid, distance, touching, degenerate, output ready);
endinterface

@@ rtl/sdu_query.sv @@
// Six-stage front end of one point-to-segment query: squared distance as num/den.
// Depends on sdu_pkg.
module sdu_query import sdu_pkg::*; #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  s0x,
  input  logic signed [W-1:0]  s0y,
  input  logic signed [W-1:0]  s1x,
  input  logic signed [W-1:0]  s1y,
  input  logic signed [W-1:0]  px,
  input  logic signed [W-1:0]  py,
  output logic [4*W+1:0]       num,
  output logic [2*W:0]         den,
  output sdu_flags_t           flags
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int MW = 2 * W + 1;
  localparam int NW = 2 * MW;
  localparam int LB = W + 1;
  localparam int HB = MW - LB;

  // Stage 1: edge and offset vectors.
  logic signed [DW-1:0] dx_r, dy_r, wx_r, wy_r, vx_r, vy_r;
  // Stage 2: products.
  logic signed [PW-1:0] dwx_r, dwy_r, ddx_r, ddy_r, cxa_r, cxb_r;
  logic signed [PW-1:0] wwx_r, wwy_r, vvx_r, vvy_r;
  // Stage 3: dot, length, cross and endpoint squares.
  logic signed [PW-1:0] dot_r, len2_r, cross_r, ww_r, vv_r;
  // Stage 4.
  logic              gap0_r, gap1_r, czero_r, pos4_r, neg4_r;
  logic [MW-1:0]     cmag_r, len2m_r, ww4_r, vv4_r;
  // Stage 5.
  logic [2*HB-1:0]   hh_r;
  logic [HB+LB-1:0]  hl_r;
  logic [2*LB-1:0]   ll_r;
  logic              gap_r;
  logic [MW-1:0]     gapv_r, len25_r;
  sdu_flags_t        flags5_r;
  // Stage 6.
  logic [NW-1:0]     num_r;
  logic [MW-1:0]     den_r;
  sdu_flags_t        flags6_r;
  logic [NW-1:0]     csq;
  logic [HB-1:0]     ch;
  logic [LB-1:0]     cl;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'(s1x) - DW'(s0x);
      dy_r <= DW'(s1y) - DW'(s0y);
      wx_r <= DW'(px) - DW'(s0x);
      wy_r <= DW'(py) - DW'(s0y);
      vx_r <= DW'(px) - DW'(s1x);
      vy_r <= DW'(py) - DW'(s1y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dwx_r <= dx_r * wx_r;
      dwy_r <= dy_r * wy_r;
      ddx_r <= dx_r * dx_r;
      ddy_r <= dy_r * dy_r;
      cxa_r <= dx_r * wy_r;
      cxb_r <= dy_r * wx_r;
      wwx_r <= wx_r * wx_r;
      wwy_r <= wy_r * wy_r;
      vvx_r <= vx_r * vx_r;
      vvy_r <= vy_r * vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r   <= dwx_r + dwy_r;
      len2_r  <= ddx_r + ddy_r;
      cross_r <= cxa_r - cxb_r;
      ww_r    <= wwx_r + wwy_r;
      vv_r    <= vvx_r + vvy_r;
    end
  end

  // The projection falls on or before the start, or on or past the end:
  // then the endpoint distance applies.
  always_ff @(posedge clk) begin
    if (en) begin
      gap0_r  <= (dot_r <= 0);
      gap1_r  <= (dot_r >= len2_r);
      czero_r <= (cross_r == '0);
      pos4_r  <= !cross_r[PW-1] && (cross_r != '0);
      neg4_r  <= cross_r[PW-1];
      cmag_r  <= cross_r[PW-1] ? MW'(-cross_r) : MW'(cross_r);
      len2m_r <= MW'(len2_r);
      ww4_r   <= MW'(ww_r);
      vv4_r   <= MW'(vv_r);
    end
  end

  assign ch = cmag_r[MW-1:LB];
  assign cl = cmag_r[LB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r           <= ch * ch;
      hl_r           <= ch * cl;
      ll_r           <= cl * cl;
      gap_r          <= gap0_r || gap1_r;
      gapv_r         <= gap0_r ? ww4_r : vv4_r;
      len25_r        <= len2m_r;
      flags5_r.zero  <= gap0_r ? (ww4_r == '0) : (gap1_r ? (vv4_r == '0) : czero_r);
      flags5_r.pos   <= pos4_r;
      flags5_r.neg   <= neg4_r;
    end
  end

  // Square of the cross product from its partial products.
  assign csq = (NW'(hh_r) << (2 * LB)) + (NW'(hl_r) << (LB + 1)) + NW'(ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= gap_r ? NW'(gapv_r) : csq;
      den_r    <= gap_r ? MW'(1) : len25_r;
      flags6_r <= flags5_r;
    end
  end

  assign num   = num_r;
  assign den   = den_r;
  assign flags = flags6_r;

endmodule

@@ rtl/sdu_div.sv @@
// Restoring divider pipeline, one quotient bit per stage.
// Depends on sdu_pkg; the quotient is known to fit in 2*W+1 bits.
module sdu_div import sdu_pkg::*; #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [4*W+1:0] num,
  input  logic [2*W:0]   den,
  input  sdu_flags_t     flags_in,
  output logic [2*W:0]   quo,
  output sdu_flags_t     flags_out
);

  localparam int MW = 2 * W + 1;
  localparam int NW = 2 * MW;

  logic [MW-1:0] rem_r [MW-1];
  logic [MW-1:0] low_r [MW-1];
  logic [MW-1:0] den_r [MW-1];
  logic [MW-1:0] quo_r [MW];
  sdu_flags_t    flg_r [MW];

  for (genvar k = 0; k < MW; k++) begin : g_step
    logic [MW-1:0] rem_in, low_in, den_in, quo_in;
    sdu_flags_t    flg_in;
    logic [MW:0]   trial;
    logic          fit;

    if (k == 0) begin : g_first
      assign rem_in = num[NW-1:MW];
      assign low_in = num[MW-1:0];
      assign den_in = den;
      assign quo_in = '0;
      assign flg_in = flags_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign flg_in = flg_r[k-1];
    end

    assign trial = {rem_in, low_in[MW-1]};
    assign fit   = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[MW-2:0], fit};
        flg_r[k] <= flg_in;
      end
    end

    if (k < MW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fit ? MW'(trial - {1'b0, den_in}) : trial[MW-1:0];
          low_r[k] <= {low_in[MW-2:0], 1'b0};
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo       = quo_r[MW-1];
  assign flags_out = flg_r[MW-1];

endmodule

@@ rtl/sdu_sqrt.sv @@
// Integer square root pipeline, one root bit per stage.
// Depends on sdu_pkg; the radicand has 2*W+1 bits, the root W+1.
module sdu_sqrt import sdu_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [2*W:0] rad,
  input  sdu_tail_t    tail_in,
  output logic [W:0]   root,
  output sdu_tail_t    tail_out
);

  localparam int RW = W + 1;
  localparam int VW = 2 * RW;

  logic [VW-1:0] val_r  [RW-1];
  logic [RW:0]   rem_r  [RW-1];
  logic [RW-1:0] root_r [RW];
  sdu_tail_t     tail_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [VW-1:0] val_in;
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    sdu_tail_t     tail_in_k;
    logic [RW+2:0] acc;
    logic [RW+2:0] trial;
    logic          fit;

    if (k == 0) begin : g_first
      assign val_in    = {1'b0, rad};
      assign rem_in    = '0;
      assign root_in   = '0;
      assign tail_in_k = tail_in;
    end else begin : g_next
      assign val_in    = val_r[k-1];
      assign rem_in    = rem_r[k-1];
      assign root_in   = root_r[k-1];
      assign tail_in_k = tail_r[k-1];
    end

    // The remainder never exceeds twice the partial root, so RW+1 bits hold it.
    assign acc   = {rem_in, val_in[VW-1:VW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign fit   = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tail_r[k] <= '0;
      end else if (en) begin
        tail_r[k] <= tail_in_k;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[RW-2:0], fit};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fit ? (RW+1)'(acc - trial) : acc[RW:0];
          val_r[k] <= {val_in[VW-3:0], 2'b00};
        end
      end
    end
  end

  assign root     = root_r[RW-1];
  assign tail_out = tail_r[RW-1];

endmodule

@@ rtl/segment_distance_unit.sv @@
// Top level of the segment distance unit: query front ends, dividers, minimum,
// square root and output skid. Depends on sdu_pkg, sdu_if, sdu_query, sdu_div,
// sdu_sqrt and segment_distance_unit_assert.svh.
//
// Usage: in_ch carries one query per transaction: cmd selects segment to
// segment (the distance between A and B) or segment to point (A and the point
// B start). out_ch returns one transaction per query, in order: the floor of
// the Euclidean distance, a touching flag and a degenerate flag.
// Throughput is one transaction per cycle while the skid register is empty.
// From acceptance to the result on out_ch a query passes the query front ends
// (products and sums), 2*COORD_WIDTH+1 divider stages (one quotient bit each),
// minimum selection in the m1 and m2 registers, COORD_WIDTH+1 square root stages
// (one root bit each) and the output register.
// Reset clears every valid bit; the data registers of the datapath are not reset.
// When out_ch stalls, one result moves into a skid register and the whole
// pipeline then freezes; in_ch.ready falls until the skid register drains.
`include "segment_distance_unit_assert.svh"

module segment_distance_unit import sdu_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sdu_in_if.sink    in_ch,
  sdu_out_if.source out_ch
);

  localparam int W         = COORD_WIDTH;
  localparam int MW        = 2 * W + 1;
  localparam int NW        = 2 * MW;
  localparam int RW        = W + 1;
  localparam int FRONT_LAT = QUERY_LAT + MW;

  logic          pipe_en;
  sdu_side_t     side_nxt;
  sdu_side_t     side_r [FRONT_LAT];
  sdu_side_t     side_end;

  logic [NW-1:0] qnum  [QRY_NUM];
  logic [MW-1:0] qden  [QRY_NUM];
  sdu_flags_t    qflg  [QRY_NUM];
  logic [MW-1:0] quo   [QRY_NUM];
  sdu_flags_t    dflg  [QRY_NUM];

  logic          proper, seg_touch, touch_nxt;
  logic [MW-1:0] lo01_nxt, lo23_nxt;
  logic          m1_valid_r, m1_touch_r, m1_deg_r;
  sdu_cmd_t      m1_cmd_r;
  logic [MW-1:0] lo01_r, lo23_r;
  logic [MW-1:0] m2_val_r, m2_val_nxt;
  sdu_tail_t     m2_tail_r;

  logic [RW-1:0] root_q;
  sdu_tail_t     root_tail;

  logic          out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic [RW-1:0] out_dist_r, out_dist_nxt, skid_dist_r, skid_dist_nxt;
  logic          out_touch_r, out_touch_nxt, skid_touch_r, skid_touch_nxt;
  logic          out_deg_r, out_deg_nxt, skid_deg_r, skid_deg_nxt;
  logic          produce, out_load;

  // The pipeline moves as a whole whenever the skid register is free.
  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  always_comb begin
    side_nxt.valid = in_ch.valid;
    side_nxt.cmd   = sdu_cmd_t'(in_ch.cmd);
    side_nxt.adeg  = (in_ch.a_start_x == in_ch.a_end_x) &&
                     (in_ch.a_start_y == in_ch.a_end_y);
    side_nxt.bdeg  = (in_ch.b_start_x == in_ch.b_end_x) &&
                     (in_ch.b_start_y == in_ch.b_end_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (pipe_en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < FRONT_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign side_end = side_r[FRONT_LAT-1];

  sdu_query #(.W(W)) u_qry_b_a0 (
    .clk(clk), .en(pipe_en),
    .s0x(in_ch.b_start_x), .s0y(in_ch.b_start_y),
    .s1x(in_ch.b_end_x), .s1y(in_ch.b_end_y),
    .px(in_ch.a_start_x), .py(in_ch.a_start_y),
    .num(qnum[QRY_B_A0]), .den(qden[QRY_B_A0]), .flags(qflg[QRY_B_A0])
  );

  sdu_query #(.W(W)) u_qry_b_a1 (
    .clk(clk), .en(pipe_en),
    .s0x(in_ch.b_start_x), .s0y(in_ch.b_start_y),
    .s1x(in_ch.b_end_x), .s1y(in_ch.b_end_y),
    .px(in_ch.a_end_x), .py(in_ch.a_end_y),
    .num(qnum[QRY_B_A1]), .den(qden[QRY_B_A1]), .flags(qflg[QRY_B_A1])
  );

  sdu_query #(.W(W)) u_qry_a_b0 (
    .clk(clk), .en(pipe_en),
    .s0x(in_ch.a_start_x), .s0y(in_ch.a_start_y),
    .s1x(in_ch.a_end_x), .s1y(in_ch.a_end_y),
    .px(in_ch.b_start_x), .py(in_ch.b_start_y),
    .num(qnum[QRY_A_B0]), .den(qden[QRY_A_B0]), .flags(qflg[QRY_A_B0])
  );

  sdu_query #(.W(W)) u_qry_a_b1 (
    .clk(clk), .en(pipe_en),
    .s0x(in_ch.a_start_x), .s0y(in_ch.a_start_y),
    .s1x(in_ch.a_end_x), .s1y(in_ch.a_end_y),
    .px(in_ch.b_end_x), .py(in_ch.b_end_y),
    .num(qnum[QRY_A_B1]), .den(qden[QRY_A_B1]), .flags(qflg[QRY_A_B1])
  );

  for (genvar i = 0; i < QRY_NUM; i++) begin : g_div
    sdu_div #(.W(W)) u_div (
      .clk(clk), .en(pipe_en),
      .num(qnum[i]), .den(qden[i]), .flags_in(qflg[i]),
      .quo(quo[i]), .flags_out(dflg[i])
    );
  end

  // Proper crossing: each segment's endpoints lie strictly on opposite sides
  // of the other segment's line.
  always_comb begin
    proper = ((dflg[QRY_A_B0].pos && dflg[QRY_A_B1].neg) ||
              (dflg[QRY_A_B0].neg && dflg[QRY_A_B1].pos)) &&
             ((dflg[QRY_B_A0].pos && dflg[QRY_B_A1].neg) ||
              (dflg[QRY_B_A0].neg && dflg[QRY_B_A1].pos));
    seg_touch = proper || dflg[QRY_B_A0].zero || dflg[QRY_B_A1].zero ||
                dflg[QRY_A_B0].zero || dflg[QRY_A_B1].zero;
    touch_nxt = (side_end.cmd == CMD_SEG_PT) ? dflg[QRY_A_B0].zero : seg_touch;
    lo01_nxt  = (quo[QRY_B_A1] < quo[QRY_B_A0]) ? quo[QRY_B_A1] : quo[QRY_B_A0];
    if (side_end.cmd == CMD_SEG_PT) begin
      lo23_nxt = quo[QRY_A_B0];
    end else begin
      lo23_nxt = (quo[QRY_A_B1] < quo[QRY_A_B0]) ? quo[QRY_A_B1] : quo[QRY_A_B0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      m1_valid_r <= side_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_cmd_r   <= side_end.cmd;
      m1_touch_r <= touch_nxt;
      m1_deg_r   <= (side_end.cmd == CMD_SEG_PT) ? side_end.adeg
                                                  : (side_end.adeg || side_end.bdeg);
      lo01_r     <= lo01_nxt;
      lo23_r     <= lo23_nxt;
    end
  end

  // The root is monotonic, so the least squared distance gives the answer.
  always_comb begin
    if (m1_touch_r) begin
      m2_val_nxt = '0;
    end else if (m1_cmd_r == CMD_SEG_PT) begin
      m2_val_nxt = lo23_r;
    end else begin
      m2_val_nxt = (lo01_r < lo23_r) ? lo01_r : lo23_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_tail_r <= '0;
    end else if (pipe_en) begin
      m2_tail_r.valid      <= m1_valid_r;
      m2_tail_r.touching   <= m1_touch_r;
      m2_tail_r.degenerate <= m1_deg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m2_val_r <= m2_val_nxt;
    end
  end

  sdu_sqrt #(.W(W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .rad(m2_val_r), .tail_in(m2_tail_r),
    .root(root_q), .tail_out(root_tail)
  );

  // Output register with a one-entry skid register behind it.
  assign produce  = pipe_en && root_tail.valid;
  assign out_load = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_dist_nxt   = out_dist_r;
    out_touch_nxt  = out_touch_r;
    out_deg_nxt    = out_deg_r;
    skid_valid_nxt = skid_valid_r;
    skid_dist_nxt  = skid_dist_r;
    skid_touch_nxt = skid_touch_r;
    skid_deg_nxt   = skid_deg_r;
    if (out_load) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_dist_nxt   = skid_dist_r;
        out_touch_nxt  = skid_touch_r;
        out_deg_nxt    = skid_deg_r;
        skid_valid_nxt = 1'b0;
      end else if (produce) begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = root_q;
        out_touch_nxt = root_tail.touching;
        out_deg_nxt   = root_tail.degenerate;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_dist_nxt  = root_q;
      skid_touch_nxt = root_tail.touching;
      skid_deg_nxt   = root_tail.degenerate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r   <= out_dist_nxt;
    out_touch_r  <= out_touch_nxt;
    out_deg_r    <= out_deg_nxt;
    skid_dist_r  <= skid_dist_nxt;
    skid_touch_r <= skid_touch_nxt;
    skid_deg_r   <= skid_deg_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance   = out_dist_r;
  assign out_ch.touching   = out_touch_r;
  assign out_ch.degenerate = out_deg_r;

  `SDU_ASSERT_NOW(a_touch_zero, clk, rst_n, out_valid_r && out_touch_r, out_dist_r == '0)
  `SDU_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SDU_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_r && !out_ch.ready, skid_valid_r && $stable(skid_dist_r))
  `SDU_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, skid_valid_r, $stable(root_q))

endmodule

@@ dv/tb.sv @@
// Self-checking testbench of segment_distance_unit: directed and random queries.
// Depends on sdu_pkg, sdu_if and the segment_distance_unit RTL.
`timescale 1ns / 1ps

module tb;
  import sdu_pkg::*;

  localparam int CW = 32;
  localparam int LIMIT = 400000;
  localparam int TAIL = 150;
  localparam int N_RANDOM = 900;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 400;
  localparam int BUSY_FROM = 800;
  localparam int BUSY_TO = 1100;

  typedef logic signed [199:0] wide_t;

  typedef struct {
    sdu_cmd_t              cmd;
    logic signed [CW-1:0]  c[8];  // a start x,y, a end x,y, b start x,y, b end x,y
  } query_t;

  typedef struct {
    logic [CW:0] gap;
    logic        touch;
    logic        deg;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      known;
    answer_t a;
  } row_t;

  logic clk;
  logic rst_n;
  sdu_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  sdu_out_if #(.COORD_WIDTH(CW)) out_ch ();

  segment_distance_unit #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  row_t    rows[$];
  answer_t answers_due[$];
  int      next_row;
  int      cycle;
  int      errors;
  int      n_touch, n_deg, n_point;
  int      hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- Predictor ----------------
  function automatic int sign_of(wide_t v);
    if (v == 0) return 0;
    return (v < 0) ? -1 : 1;
  endfunction

  function automatic wide_t cross_of(wide_t ux, wide_t uy, wide_t vx, wide_t vy);
    return ux * vy - uy * vx;
  endfunction

  // Largest q below 2^33 with q*q*den <= num.
  function automatic logic [CW:0] floor_root(wide_t num, wide_t den);
    wide_t q, cand;
    q = 0;
    for (int b = CW; b >= 0; b--) begin
      cand = q | (wide_t'(1) << b);
      if (cand * cand * den <= num) q = cand;
    end
    return q[CW:0];
  endfunction

  function automatic logic [CW:0] point_seg_gap(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                                wide_t px, wide_t py, output logic zero);
    wide_t dx, dy, wx, wy, d, len2, cr, s;
    dx = bx - ax; dy = by - ay;
    wx = px - ax; wy = py - ay;
    d = dx * wx + dy * wy;
    len2 = dx * dx + dy * dy;
    if (d <= 0) begin
      s = wx * wx + wy * wy;
      zero = (s == 0);
      return floor_root(s, 1);
    end
    if (d >= len2) begin
      s = (px - bx) * (px - bx) + (py - by) * (py - by);
      zero = (s == 0);
      return floor_root(s, 1);
    end
    cr = cross_of(dx, dy, wx, wy);
    zero = (cr == 0);
    return floor_root(cr * cr, len2);
  endfunction

  function automatic answer_t distance_of(query_t q);
    answer_t r;
    wide_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic adeg, bdeg, z1, z2, z3, z4, proper;
    logic [CW:0] d1, d2, d3, d4, m;
    int o1, o2, o3, o4;
    ax0 = q.c[0]; ay0 = q.c[1]; ax1 = q.c[2]; ay1 = q.c[3];
    bx0 = q.c[4]; by0 = q.c[5]; bx1 = q.c[6]; by1 = q.c[7];
    adeg = (ax0 == ax1) && (ay0 == ay1);
    bdeg = (bx0 == bx1) && (by0 == by1);
    if (q.cmd == CMD_SEG_PT) begin
      r.gap = point_seg_gap(ax0, ay0, ax1, ay1, bx0, by0, z1);
      r.touch = z1;
      r.deg = adeg;
    end else begin
      o1 = sign_of(cross_of(ax1 - ax0, ay1 - ay0, bx0 - ax0, by0 - ay0));
      o2 = sign_of(cross_of(ax1 - ax0, ay1 - ay0, bx1 - ax0, by1 - ay0));
      o3 = sign_of(cross_of(bx1 - bx0, by1 - by0, ax0 - bx0, ay0 - by0));
      o4 = sign_of(cross_of(bx1 - bx0, by1 - by0, ax1 - bx0, ay1 - by0));
      proper = (o1 * o2 < 0) && (o3 * o4 < 0);
      d1 = point_seg_gap(bx0, by0, bx1, by1, ax0, ay0, z1);
      d2 = point_seg_gap(bx0, by0, bx1, by1, ax1, ay1, z2);
      d3 = point_seg_gap(ax0, ay0, ax1, ay1, bx0, by0, z3);
      d4 = point_seg_gap(ax0, ay0, ax1, ay1, bx1, by1, z4);
      m = d1;
      if (d2 < m) m = d2;
      if (d3 < m) m = d3;
      if (d4 < m) m = d4;
      r.touch = proper || z1 || z2 || z3 || z4;
      r.gap = r.touch ? '0 : m;
      r.deg = adeg || bdeg;
    end
    return r;
  endfunction

  // ---------------- Stimulus ----------------
  function automatic query_t mk_query(sdu_cmd_t cmd, int ax, int ay, int bx, int by,
                                      int cx, int cy, int dx, int dy);
    query_t q;
    q.cmd = cmd;
    q.c[0] = ax; q.c[1] = ay; q.c[2] = bx; q.c[3] = by;
    q.c[4] = cx; q.c[5] = cy; q.c[6] = dx; q.c[7] = dy;
    return q;
  endfunction

  task automatic add_row(query_t q, bit known, logic [CW:0] gap = 0, logic touch = 0,
                         logic deg = 0);
    row_t r;
    r.q = q;
    r.known = known;
    r.a.gap = gap; r.a.touch = touch; r.a.deg = deg;
    rows = {rows, r};
  endtask

  function automatic int grid_coord();
    int v;
    v = int'($urandom_range(0, 64)) - 32;
    return v <<< $urandom_range(0, 16);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind, bx, by, sx, sy;
    kind = $urandom_range(0, 99);
    q.cmd = sdu_cmd_t'($urandom_range(0, 1));
    for (int i = 0; i < 8; i++) q.c[i] = (kind < 25) ? $urandom : grid_coord();
    if (kind >= 55 && kind < 65) begin
      // Zero-length segment on one side, A or B, picked at random.
      if ($urandom_range(0, 1)) begin q.c[2] = q.c[0]; q.c[3] = q.c[1]; end
      else begin q.c[6] = q.c[4]; q.c[7] = q.c[5]; end
    end else if (kind >= 65 && kind < 78) begin
      // All four points on one line: overlap, touch at an end, or a gap.
      q.cmd = ($urandom_range(0, 3) == 0) ? CMD_SEG_PT : CMD_SEG_SEG;
      bx = grid_coord(); by = grid_coord();
      sx = int'($urandom_range(0, 8)) - 4; sy = int'($urandom_range(0, 8)) - 4;
      for (int i = 0; i < 4; i++) begin
        int t;
        t = int'($urandom_range(0, 20)) - 10;
        q.c[2*i] = bx + t * sx * 4096;
        q.c[2*i+1] = by + t * sy * 4096;
      end
    end else if (kind >= 78) begin
      q.cmd = CMD_SEG_PT;
    end
    return q;
  endfunction

  initial begin
    // Degenerate and coincident cases.
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 1);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 1);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 0, 0, 3, 4, 9, 9), 1, 5, 0, 1);
    add_row(mk_query(CMD_SEG_SEG, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1, 0, 1, 1);
    add_row(mk_query(CMD_SEG_PT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000, 0, 0), 1, 0, 1, 1);
    // Crossing and collinear overlap.
    add_row(mk_query(CMD_SEG_SEG, -65536, -65536, 65536, 65536, -65536, 65536, 65536, -65536),
            1, 0, 1, 0);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 4, 0, 2, 0, 6, 0), 1, 0, 1, 0);
    // Point mode: interior projection, on an endpoint, beyond each end, on the segment.
    add_row(mk_query(CMD_SEG_PT, 0, 0, 10, 0, 5, 7, 0, 0), 1, 7, 0, 0);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 10, 0, 10, 3, 0, 0), 1, 3, 0, 0);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 10, 0, 13, 4, 0, 0), 1, 5, 0, 0);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 10, 0, -3, -4, 0, 0), 1, 5, 0, 0);
    add_row(mk_query(CMD_SEG_PT, 0, 0, 10, 0, 4, 0, 0, 0), 1, 0, 1, 0);
    // Extremes of the coordinate range.
    add_row(mk_query(CMD_SEG_PT, 32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0),
            1, 33'd2147483647, 0, 0);
    add_row(mk_query(CMD_SEG_PT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 0, 0), 0);
    add_row(mk_query(CMD_SEG_SEG, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                     32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff), 0);
    add_row(mk_query(CMD_SEG_SEG, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000), 1, 0, 1, 0);
    // Parallel apart, T junction, near miss, end to end touch, zero-length B, two predictor-only rows.
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 10, 0, 0, 3, 10, 3), 1, 3, 0, 0);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 10, 0, 5, 0, 5, 9), 1, 0, 1, 0);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 10, 0, 5, 1, 5, 9), 1, 1, 0, 0);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 10, 0, 10, 0, 20, 5), 1, 0, 1, 0);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 10, 0, 13, 4, 13, 4), 1, 5, 0, 1);
    add_row(mk_query(CMD_SEG_SEG, 0, 0, 2, 1, 7, 3, 100, 77), 0);
    add_row(mk_query(CMD_SEG_PT, 32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0,
                     32'h55555555, 32'haaaaaaaa, 32'h7fffffff, 32'h80000000), 0);
    for (int i = 0; i < N_RANDOM; i++) add_row(random_query(), 0);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.a_start_x = '0; in_ch.a_start_y = '0; in_ch.a_end_x = '0; in_ch.a_end_y = '0;
    in_ch.b_start_x = '0; in_ch.b_start_y = '0; in_ch.b_end_x = '0; in_ch.b_end_y = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idling is switched off in a stretch of the run.
  function automatic bit idle_roll();
    if (cycle >= BUSY_FROM && cycle < BUSY_TO) return 0;
    return $urandom_range(0, 99) < 10;
  endfunction

  // ---------------- Sender ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      next_row <= 0;
    end else begin
      automatic int idx = next_row;
      if (in_ch.valid && in_ch.ready) begin
        automatic row_t r = rows[idx];
        automatic answer_t p = distance_of(r.q);
        automatic answer_t due = r.known ? r.a : p;
        if (r.known && (p.gap !== r.a.gap || p.touch !== r.a.touch || p.deg !== r.a.deg))
        begin
          $display("%0t row %0d: expected %0d/%0b/%0b, predictor %0d/%0b/%0b", $time, idx,
                   r.a.gap, r.a.touch, r.a.deg, p.gap, p.touch, p.deg);
          errors++;
        end
        answers_due = {answers_due, due};
        if (r.q.cmd == CMD_SEG_PT) n_point++;
        idx++;
        next_row <= idx;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (idx < rows.size() && !idle_roll()) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= rows[idx].q.cmd;
          in_ch.a_start_x <= rows[idx].q.c[0]; in_ch.a_start_y <= rows[idx].q.c[1];
          in_ch.a_end_x <= rows[idx].q.c[2];   in_ch.a_end_y <= rows[idx].q.c[3];
          in_ch.b_start_x <= rows[idx].q.c[4]; in_ch.b_start_y <= rows[idx].q.c[5];
          in_ch.b_end_x <= rows[idx].q.c[6];   in_ch.b_end_y <= rows[idx].q.c[7];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- Long hold-off counter ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (cycle == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- Receiver and checker ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t unexpected result transaction: distance %0d", $time,
                   out_ch.distance);
          errors++;
        end else begin
          automatic answer_t e = answers_due.pop_front();
          if (out_ch.distance !== e.gap) begin
            $display("%0t distance: expected %0d, actual %0d", $time, e.gap,
                     out_ch.distance);
            errors++;
          end
          if (out_ch.touching !== e.touch) begin
            $display("%0t touching: expected %0b, actual %0b", $time, e.touch,
                     out_ch.touching);
            errors++;
          end
          if (out_ch.degenerate !== e.deg) begin
            $display("%0t degenerate: expected %0b, actual %0b", $time, e.deg,
                     out_ch.degenerate);
            errors++;
          end
          if (e.touch) n_touch++;
          if (e.deg) n_deg++;
        end
      end
      // One long hold-off lets the pipeline fill and push back on the input.
      if (cycle == HOLD_AT || hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_roll();
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("** segment_distance_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    cycle = 0;
    errors = 0;
    n_touch = 0; n_deg = 0; n_point = 0;
    wait (rst_n === 1'b1);
    wait (rows.size() > 0 && next_row == rows.size());
    wait (answers_due.size() == 0);
    repeat (TAIL) @(posedge clk);
    $display("Ran %0d queries (%0d point mode), %0d touching and %0d degenerate results,",
             rows.size(), n_point, n_touch, n_deg);
    $display("with random idling on both sides and one long output stall.");
    if (errors == 0) begin
      $display("** segment_distance_unit: PASSED **");
    end else begin
      $display("** segment_distance_unit: FAILED **");
    end
    $finish;
  end

endmodule
